// File: sv/bfdt_pkg.sv
// ----------------------------------------------------------------------------
// bfdt_pkg
// Shared constants and types for the brute-force Delaunay triangulator.
// ----------------------------------------------------------------------------
package bfdt_pkg;

   localparam int MAX_POINTS = 32;
   localparam int MIN_POINTS = 3;
   localparam int RESULT_CAP = 64;

   localparam int IDX_W     = $clog2(MAX_POINTS);
   localparam int CNT_W     = $clog2(MAX_POINTS + 1);
   localparam int CAP_W     = $clog2(RESULT_CAP + 1);
   localparam int COORD_W   = 16;
   localparam int TOL_W     = 16;
   localparam int IDX_OUT_W = 5;

   // datapath widths of the exact incircle evaluation
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LIFT_W  = 2 * DIFF_W;
   localparam int COF_W   = 2 * DIFF_W + 1;
   localparam int LPART_W = DIFF_W;
   localparam int MUL_A_W = COF_W + 1;
   localparam int MUL_B_W = LPART_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DET_W   = 72;
   localparam int STEP_W  = 5;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   localparam int PT_W = $bits(point_type);

endpackage

// File: sv/bfdt_ram.sv
// ----------------------------------------------------------------------------
// bfdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/brute_force_delaunay_triangulation.sv
// ----------------------------------------------------------------------------
// brute_force_delaunay_triangulation
// Loads up to 32 integer points, then emits at most 64 triangles whose
// circumcircle holds no other point, by an exact integer incircle determinant.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     x_coord, y_coord, last_point
//   rsp      out        rsp_valid/stall     index_a/b/c, found, last_result
//   csr      in         csr_write_enable    collinear_tolerance (16 bit)
//
// Point items are taken while the block is loading. The item marked last
// starts the search: each triple first reads its corners and forms the
// orientation product; unless it is collinear, other points are tested
// against it on the one shared 36x18 multiplier, which runs 18 partial
// products per test. Synchronous active-high reset clears control and the
// tolerance; the point store needs no clearing. req_stall stays high during
// the search; a held result on rsp does not block loading new points.
//
module brute_force_delaunay_triangulation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bfdt_pkg::COORD_W-1:0]   req_x_coord,
   input  logic signed [bfdt_pkg::COORD_W-1:0]   req_y_coord,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bfdt_pkg::IDX_OUT_W-1:0]        rsp_index_a,
   output logic [bfdt_pkg::IDX_OUT_W-1:0]        rsp_index_b,
   output logic [bfdt_pkg::IDX_OUT_W-1:0]        rsp_index_c,
   output logic                                  rsp_found,
   output logic                                  rsp_last_result,
   input  logic                                  csr_write_enable,
   input  logic [bfdt_pkg::TOL_W-1:0]            csr_write_data
);

   localparam int IW = bfdt_pkg::IDX_W;
   localparam int CW = bfdt_pkg::CNT_W;
   localparam int SW = 5;

   // sequencer states
   localparam logic [SW-1:0] ST_LOAD   = 5'd0;
   localparam logic [SW-1:0] ST_START  = 5'd1;
   localparam logic [SW-1:0] ST_RD_I   = 5'd2;
   localparam logic [SW-1:0] ST_RD_J   = 5'd3;
   localparam logic [SW-1:0] ST_RD_K   = 5'd4;
   localparam logic [SW-1:0] ST_CAP_K  = 5'd5;
   localparam logic [SW-1:0] ST_TDIFF  = 5'd6;
   localparam logic [SW-1:0] ST_OMUL   = 5'd7;
   localparam logic [SW-1:0] ST_ODRAIN = 5'd8;
   localparam logic [SW-1:0] ST_OCHK   = 5'd9;
   localparam logic [SW-1:0] ST_M_SEL  = 5'd10;
   localparam logic [SW-1:0] ST_M_CAP  = 5'd11;
   localparam logic [SW-1:0] ST_CMUL   = 5'd12;
   localparam logic [SW-1:0] ST_CDRAIN = 5'd13;
   localparam logic [SW-1:0] ST_CCHK   = 5'd14;
   localparam logic [SW-1:0] ST_FOUND  = 5'd15;
   localparam logic [SW-1:0] ST_NEXT   = 5'd16;
   localparam logic [SW-1:0] ST_FINAL  = 5'd17;

   // multiplier steps: squares, cofactors, lifted terms, orientation
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_AXX = 5'd0;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_AYY = 5'd1;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_BXX = 5'd2;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_BYY = 5'd3;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CXX = 5'd4;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CYY = 5'd5;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CA0 = 5'd6;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CA1 = 5'd7;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CB0 = 5'd8;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CB1 = 5'd9;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CC0 = 5'd10;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_CC1 = 5'd11;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TAL = 5'd12;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TAH = 5'd13;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TBL = 5'd14;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TBH = 5'd15;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TCL = 5'd16;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_TCH = 5'd17;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_OR0 = 5'd18;
   localparam logic [bfdt_pkg::STEP_W-1:0] MS_OR1 = 5'd19;

   // control
   logic [SW-1:0]                    state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    n_ff, n_in;
   logic [IW-1:0]                    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]                    m_ff, m_in;
   logic [bfdt_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [bfdt_pkg::STEP_W-1:0]      acc_step_ff;
   logic                             acc_en_ff;
   logic [bfdt_pkg::CAP_W-1:0]       cnt_ff, cnt_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [IW-1:0]                    pend_a_ff, pend_a_in, pend_b_ff, pend_b_in;
   logic [IW-1:0]                    pend_c_ff, pend_c_in;
   logic [bfdt_pkg::TOL_W-1:0]       tol_ff;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]                    out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [IW-1:0]                    out_c_ff, out_c_in;
   logic                             out_found_ff, out_found_in;
   logic                             out_last_ff, out_last_in;

   // datapath
   bfdt_pkg::point_type              pi_ff, pi_in, pj_ff, pj_in, pk_ff, pk_in;
   bfdt_pkg::point_type              rd_pt;
   logic signed [bfdt_pkg::DIFF_W-1:0] ux_ff, ux_in, uy_ff, uy_in;
   logic signed [bfdt_pkg::DIFF_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [bfdt_pkg::DIFF_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [bfdt_pkg::DIFF_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [bfdt_pkg::DIFF_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [bfdt_pkg::LIFT_W-1:0]      la_ff, la_in, lb_ff, lb_in, lc_ff, lc_in;
   logic signed [bfdt_pkg::COF_W-1:0] ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic signed [bfdt_pkg::COF_W-1:0] orient_ff, orient_in;
   logic signed [bfdt_pkg::DET_W-1:0] det_ff, det_in;
   logic signed [bfdt_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bfdt_pkg::MUL_B_W-1:0] mul_b;
   logic signed [bfdt_pkg::PROD_W-1:0]  prod_ff, prod_in;

   // point store
   logic                             wr_en;
   logic [IW-1:0]                    rd_addr;
   logic [bfdt_pkg::PT_W-1:0]        rd_data;
   bfdt_pkg::point_type              wr_pt;

   logic                             req_take;
   logic                             out_free;
   logic                             store_full;
   logic [bfdt_pkg::COF_W-1:0]       orient_mag;
   logic                             collinear;
   logic                             in_circle;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign store_full = (count_ff == CW'(bfdt_pkg::MAX_POINTS));
   assign wr_en      = req_take && !store_full;
   assign wr_pt.x    = req_x_coord;
   assign wr_pt.y    = req_y_coord;
   assign rd_pt      = bfdt_pkg::point_type'(rd_data);

   bfdt_ram #(
      .WIDTH (bfdt_pkg::PT_W),
      .DEPTH (bfdt_pkg::MAX_POINTS)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_pt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read address: the three triangle corners, then each test point
   always_comb begin
      unique case (state_ff)
         ST_RD_I: rd_addr = i_ff;
         ST_RD_J: rd_addr = j_ff;
         ST_RD_K: rd_addr = k_ff;
         default: rd_addr = m_ff[IW-1:0];
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      unique case (step_ff)
         MS_AXX:  begin mul_a = bfdt_pkg::MUL_A_W'(ax_ff); mul_b = bfdt_pkg::MUL_B_W'(ax_ff); end
         MS_AYY:  begin mul_a = bfdt_pkg::MUL_A_W'(ay_ff); mul_b = bfdt_pkg::MUL_B_W'(ay_ff); end
         MS_BXX:  begin mul_a = bfdt_pkg::MUL_A_W'(bx_ff); mul_b = bfdt_pkg::MUL_B_W'(bx_ff); end
         MS_BYY:  begin mul_a = bfdt_pkg::MUL_A_W'(by_ff); mul_b = bfdt_pkg::MUL_B_W'(by_ff); end
         MS_CXX:  begin mul_a = bfdt_pkg::MUL_A_W'(cx_ff); mul_b = bfdt_pkg::MUL_B_W'(cx_ff); end
         MS_CYY:  begin mul_a = bfdt_pkg::MUL_A_W'(cy_ff); mul_b = bfdt_pkg::MUL_B_W'(cy_ff); end
         MS_CA0:  begin mul_a = bfdt_pkg::MUL_A_W'(bx_ff); mul_b = bfdt_pkg::MUL_B_W'(cy_ff); end
         MS_CA1:  begin mul_a = bfdt_pkg::MUL_A_W'(cx_ff); mul_b = bfdt_pkg::MUL_B_W'(by_ff); end
         MS_CB0:  begin mul_a = bfdt_pkg::MUL_A_W'(cx_ff); mul_b = bfdt_pkg::MUL_B_W'(ay_ff); end
         MS_CB1:  begin mul_a = bfdt_pkg::MUL_A_W'(ax_ff); mul_b = bfdt_pkg::MUL_B_W'(cy_ff); end
         MS_CC0:  begin mul_a = bfdt_pkg::MUL_A_W'(ax_ff); mul_b = bfdt_pkg::MUL_B_W'(by_ff); end
         MS_CC1:  begin mul_a = bfdt_pkg::MUL_A_W'(bx_ff); mul_b = bfdt_pkg::MUL_B_W'(ay_ff); end
         MS_TAL:  begin
            mul_a = bfdt_pkg::MUL_A_W'(ca_ff);
            mul_b = signed'({1'b0, la_ff[bfdt_pkg::LPART_W-1:0]});
         end
         MS_TAH:  begin
            mul_a = bfdt_pkg::MUL_A_W'(ca_ff);
            mul_b = signed'({1'b0, la_ff[bfdt_pkg::LIFT_W-1:bfdt_pkg::LPART_W]});
         end
         MS_TBL:  begin
            mul_a = bfdt_pkg::MUL_A_W'(cb_ff);
            mul_b = signed'({1'b0, lb_ff[bfdt_pkg::LPART_W-1:0]});
         end
         MS_TBH:  begin
            mul_a = bfdt_pkg::MUL_A_W'(cb_ff);
            mul_b = signed'({1'b0, lb_ff[bfdt_pkg::LIFT_W-1:bfdt_pkg::LPART_W]});
         end
         MS_TCL:  begin
            mul_a = bfdt_pkg::MUL_A_W'(cc_ff);
            mul_b = signed'({1'b0, lc_ff[bfdt_pkg::LPART_W-1:0]});
         end
         MS_TCH:  begin
            mul_a = bfdt_pkg::MUL_A_W'(cc_ff);
            mul_b = signed'({1'b0, lc_ff[bfdt_pkg::LIFT_W-1:bfdt_pkg::LPART_W]});
         end
         MS_OR0:  begin mul_a = bfdt_pkg::MUL_A_W'(ux_ff); mul_b = bfdt_pkg::MUL_B_W'(vy_ff); end
         MS_OR1:  begin mul_a = bfdt_pkg::MUL_A_W'(vx_ff); mul_b = bfdt_pkg::MUL_B_W'(uy_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // accumulate the registered product, issued in the cycle before
   always_comb begin
      la_in     = la_ff;
      lb_in     = lb_ff;
      lc_in     = lc_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      cc_in     = cc_ff;
      det_in    = det_ff;
      orient_in = orient_ff;
      if (acc_en_ff) begin
         unique case (acc_step_ff)
            MS_AXX:  la_in = bfdt_pkg::LIFT_W'(prod_ff);
            MS_AYY:  la_in = la_ff + bfdt_pkg::LIFT_W'(prod_ff);
            MS_BXX:  lb_in = bfdt_pkg::LIFT_W'(prod_ff);
            MS_BYY:  lb_in = lb_ff + bfdt_pkg::LIFT_W'(prod_ff);
            MS_CXX:  lc_in = bfdt_pkg::LIFT_W'(prod_ff);
            MS_CYY:  lc_in = lc_ff + bfdt_pkg::LIFT_W'(prod_ff);
            MS_CA0:  ca_in = bfdt_pkg::COF_W'(prod_ff);
            MS_CA1:  ca_in = ca_ff - bfdt_pkg::COF_W'(prod_ff);
            MS_CB0:  cb_in = bfdt_pkg::COF_W'(prod_ff);
            MS_CB1:  cb_in = cb_ff - bfdt_pkg::COF_W'(prod_ff);
            MS_CC0:  cc_in = bfdt_pkg::COF_W'(prod_ff);
            MS_CC1:  cc_in = cc_ff - bfdt_pkg::COF_W'(prod_ff);
            MS_TAL:  det_in = bfdt_pkg::DET_W'(prod_ff);
            MS_TAH, MS_TBH, MS_TCH:
               det_in = det_ff + (bfdt_pkg::DET_W'(prod_ff) <<< bfdt_pkg::LPART_W);
            MS_TBL, MS_TCL:
               det_in = det_ff + bfdt_pkg::DET_W'(prod_ff);
            MS_OR0:  orient_in = bfdt_pkg::COF_W'(prod_ff);
            MS_OR1:  orient_in = orient_ff - bfdt_pkg::COF_W'(prod_ff);
            default: ;
         endcase
      end
   end

   assign orient_mag = orient_ff[bfdt_pkg::COF_W-1] ? bfdt_pkg::COF_W'(-orient_ff)
                                                    : bfdt_pkg::COF_W'(orient_ff);
   assign collinear  = (orient_mag <= bfdt_pkg::COF_W'(tol_ff));
   // test point inside or on the circle: zero determinant, or sign matching
   // the triangle's orientation
   assign in_circle  = (det_ff == '0) ||
                       (det_ff[bfdt_pkg::DET_W-1] == orient_ff[bfdt_pkg::COF_W-1]);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      pend_c_in     = pend_c_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_c_in      = out_c_ff;
      out_found_in  = out_found_ff;
      out_last_in   = out_last_ff;
      pi_in         = pi_ff;
      pj_in         = pj_ff;
      pk_in         = pk_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (req_last_point) begin
                  // freeze the set size and rewind the store for the next set
                  n_in     = store_full ? count_ff : count_ff + CW'(1);
                  count_in = '0;
                  state_in = ST_START;
               end else if (!store_full) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_START: begin
            i_in   = '0;
            j_in   = IW'(1);
            k_in   = IW'(2);
            cnt_in = '0;
            if (n_ff < CW'(bfdt_pkg::MIN_POINTS)) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I:  state_in = ST_RD_J;
         ST_RD_J: begin
            pi_in    = rd_pt;
            state_in = ST_RD_K;
         end
         ST_RD_K: begin
            pj_in    = rd_pt;
            state_in = ST_CAP_K;
         end
         ST_CAP_K: begin
            pk_in    = rd_pt;
            state_in = ST_TDIFF;
         end
         ST_TDIFF: begin
            ux_in    = bfdt_pkg::DIFF_W'(pj_ff.x) - bfdt_pkg::DIFF_W'(pi_ff.x);
            uy_in    = bfdt_pkg::DIFF_W'(pj_ff.y) - bfdt_pkg::DIFF_W'(pi_ff.y);
            vx_in    = bfdt_pkg::DIFF_W'(pk_ff.x) - bfdt_pkg::DIFF_W'(pi_ff.x);
            vy_in    = bfdt_pkg::DIFF_W'(pk_ff.y) - bfdt_pkg::DIFF_W'(pi_ff.y);
            step_in  = MS_OR0;
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            if (step_ff == MS_OR1) begin
               state_in = ST_ODRAIN;
            end else begin
               step_in = step_ff + bfdt_pkg::STEP_W'(1);
            end
         end
         ST_ODRAIN: state_in = ST_OCHK;
         ST_OCHK: begin
            m_in     = '0;
            state_in = collinear ? ST_NEXT : ST_M_SEL;
         end
         ST_M_SEL: begin
            // read the test point; skip the triangle's own corners
            if (m_ff == n_ff) begin
               state_in = ST_FOUND;
            end else if (m_ff == CW'(i_ff) || m_ff == CW'(j_ff) || m_ff == CW'(k_ff)) begin
               m_in = m_ff + CW'(1);
            end else begin
               state_in = ST_M_CAP;
            end
         end
         ST_M_CAP: begin
            ax_in    = bfdt_pkg::DIFF_W'(pi_ff.x) - bfdt_pkg::DIFF_W'(rd_pt.x);
            ay_in    = bfdt_pkg::DIFF_W'(pi_ff.y) - bfdt_pkg::DIFF_W'(rd_pt.y);
            bx_in    = bfdt_pkg::DIFF_W'(pj_ff.x) - bfdt_pkg::DIFF_W'(rd_pt.x);
            by_in    = bfdt_pkg::DIFF_W'(pj_ff.y) - bfdt_pkg::DIFF_W'(rd_pt.y);
            cx_in    = bfdt_pkg::DIFF_W'(pk_ff.x) - bfdt_pkg::DIFF_W'(rd_pt.x);
            cy_in    = bfdt_pkg::DIFF_W'(pk_ff.y) - bfdt_pkg::DIFF_W'(rd_pt.y);
            step_in  = MS_AXX;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            if (step_ff == MS_TCH) begin
               state_in = ST_CDRAIN;
            end else begin
               step_in = step_ff + bfdt_pkg::STEP_W'(1);
            end
         end
         ST_CDRAIN: state_in = ST_CCHK;
         ST_CCHK: begin
            if (in_circle) begin
               state_in = ST_NEXT;
            end else begin
               m_in     = m_ff + CW'(1);
               state_in = ST_M_SEL;
            end
         end
         ST_FOUND: begin
            // hold the newest triangle back until we know whether it is last
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  out_a_in     = pend_a_ff;
                  out_b_in     = pend_b_ff;
                  out_c_in     = pend_c_ff;
                  out_found_in = 1'b1;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_a_in     = i_ff;
               pend_b_in     = j_ff;
               pend_c_in     = k_ff;
               cnt_in        = cnt_ff + bfdt_pkg::CAP_W'(1);
               if (cnt_ff + bfdt_pkg::CAP_W'(1) == bfdt_pkg::CAP_W'(bfdt_pkg::RESULT_CAP)) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            state_in = ST_RD_I;
            priority if (CW'(k_ff) + CW'(1) < n_ff) begin
               k_in = k_ff + IW'(1);
            end else if (CW'(j_ff) + CW'(2) < n_ff) begin
               j_in = j_ff + IW'(1);
               k_in = j_ff + IW'(2);
            end else if (CW'(i_ff) + CW'(3) < n_ff) begin
               i_in = i_ff + IW'(1);
               j_in = i_ff + IW'(2);
               k_in = i_ff + IW'(3);
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // release the held triangle as last, or an empty result
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_a_in      = pend_valid_ff ? pend_a_ff : '0;
               out_b_in      = pend_valid_ff ? pend_b_ff : '0;
               out_c_in      = pend_valid_ff ? pend_c_ff : '0;
               out_found_in  = pend_valid_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         acc_en_ff     <= 1'b0;
         tol_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_en_ff     <= (state_ff == ST_OMUL) || (state_ff == ST_CMUL);
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      step_ff     <= step_in;
      acc_step_ff <= step_ff;
      pend_a_ff   <= pend_a_in;
      pend_b_ff   <= pend_b_in;
      pend_c_ff   <= pend_c_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_c_ff    <= out_c_in;
      out_found_ff <= out_found_in;
      out_last_ff <= out_last_in;
      pi_ff       <= pi_in;
      pj_ff       <= pj_in;
      pk_ff       <= pk_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      lc_ff       <= lc_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      cc_ff       <= cc_in;
      orient_ff   <= orient_in;
      det_ff      <= det_in;
      prod_ff     <= prod_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_a     = bfdt_pkg::IDX_OUT_W'(out_a_ff);
   assign rsp_index_b     = bfdt_pkg::IDX_OUT_W'(out_b_ff);
   assign rsp_index_c     = bfdt_pkg::IDX_OUT_W'(out_c_ff);
   assign rsp_found       = out_found_ff;
   assign rsp_last_result = out_last_ff;

   // an empty result always closes its set
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_found_ff || out_last_ff))
      else $error("empty result without last_result");

   // triangle corners leave in strictly rising index order
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_found_ff) |-> (out_a_ff < out_b_ff && out_b_ff < out_c_ff))
      else $error("triangle indices out of order");

   // no triangle is held over once loading resumes
   a_pend_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !pend_valid_ff)
      else $error("held triangle left behind");

   // the result count never passes the cap
   a_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bfdt_pkg::CAP_W'(bfdt_pkg::RESULT_CAP))
      else $error("result count beyond cap");

endmodule

// File: test/brute_force_delaunay_triangulation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brute_force_delaunay_triangulation_test
// Feeds point sets to the triangulator, predicts every Delaunay triangle with
// an exact integer incircle test and checks each result item in order.
// ----------------------------------------------------------------------------

module brute_force_delaunay_triangulation_test;

   localparam int WATCHDOG_LIMIT = 300000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int LONG_HOLD      = 3000;

   // Predicts the triangles of each point set and holds them until they
   // arrive on the result channel.
   class triangle_scoreboard;
      typedef struct {
         bit [bfdt_pkg::IDX_OUT_W-1:0] index_a;
         bit [bfdt_pkg::IDX_OUT_W-1:0] index_b;
         bit [bfdt_pkg::IDX_OUT_W-1:0] index_c;
         bit                           found;
         bit                           last_result;
      } triangle_item;

      triangle_item expected_triangles[$];
      longint       point_x[bfdt_pkg::MAX_POINTS];
      longint       point_y[bfdt_pkg::MAX_POINTS];
      int           point_count;
      bit [bfdt_pkg::TOL_W-1:0] tolerance;
      int           mismatches;
      int           triangles_seen;
      int           empty_seen;
      int           sets_done;

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // true when point m lies inside or on the circle through i, j, k
      function bit in_or_on_circle(int i, int j, int k, int m, longint orient);
         longint ax, ay, bx, by, cx, cy;
         logic signed [127:0] la, lb, lc, ca, cb, cc, det;
         ax = point_x[i] - point_x[m];  ay = point_y[i] - point_y[m];
         bx = point_x[j] - point_x[m];  by = point_y[j] - point_y[m];
         cx = point_x[k] - point_x[m];  cy = point_y[k] - point_y[m];
         la = ax * ax + ay * ay;
         lb = bx * bx + by * by;
         lc = cx * cx + cy * cy;
         ca = bx * cy - cx * by;
         cb = cx * ay - ax * cy;
         cc = ax * by - bx * ay;
         det = la * ca + lb * cb + lc * cc;
         if (det == 0) return 1;
         return (det < 0) == (orient < 0);
      endfunction

      function void note_point(logic signed [bfdt_pkg::COORD_W-1:0] x,
                               logic signed [bfdt_pkg::COORD_W-1:0] y, bit last);
         int n, found_count, m;
         bit done, empty;
         longint orient, mag;
         triangle_item t;
         if (point_count < bfdt_pkg::MAX_POINTS) begin
            point_x[point_count] = longint'(x);
            point_y[point_count] = longint'(y);
            point_count++;
         end
         if (!last) return;
         n = point_count;
         point_count = 0;
         found_count = 0;
         done = 0;
         sets_done++;
         if (n >= bfdt_pkg::MIN_POINTS) begin
            for (int i = 0; i + 2 < n && !done; i++) begin
               for (int j = i + 1; j + 1 < n && !done; j++) begin
                  for (int k = j + 1; k < n && !done; k++) begin
                     orient = (point_x[j] - point_x[i]) * (point_y[k] - point_y[i])
                            - (point_x[k] - point_x[i]) * (point_y[j] - point_y[i]);
                     mag = orient < 0 ? -orient : orient;
                     if (mag <= longint'(tolerance)) continue;
                     empty = 1;
                     for (m = 0; m < n && empty; m++) begin
                        if (m == i || m == j || m == k) continue;
                        if (in_or_on_circle(i, j, k, m, orient)) empty = 0;
                     end
                     if (!empty) continue;
                     t.index_a = bfdt_pkg::IDX_OUT_W'(i);
                     t.index_b = bfdt_pkg::IDX_OUT_W'(j);
                     t.index_c = bfdt_pkg::IDX_OUT_W'(k);
                     t.found = 1;  t.last_result = 0;
                     expected_triangles.insert(expected_triangles.size(), t);
                     found_count++;
                     if (found_count >= bfdt_pkg::RESULT_CAP) done = 1;
                  end
               end
            end
         end
         if (found_count == 0) begin
            t.index_a = 0;  t.index_b = 0;  t.index_c = 0;
            t.found = 0;  t.last_result = 1;
            expected_triangles.insert(expected_triangles.size(), t);
         end else begin
            expected_triangles[$].last_result = 1;
         end
      endfunction

      task check_result(bit [bfdt_pkg::IDX_OUT_W-1:0] a, bit [bfdt_pkg::IDX_OUT_W-1:0] b,
                        bit [bfdt_pkg::IDX_OUT_W-1:0] c, bit found, bit last);
         triangle_item t;
         if (expected_triangles.size() == 0) begin
            report($sformatf("unexpected result %0d %0d %0d found=%0d", a, b, c, found));
            return;
         end
         t = expected_triangles.pop_front();
         if (found) triangles_seen++; else empty_seen++;
         if (a !== t.index_a) report($sformatf("index_a %0d, want %0d", a, t.index_a));
         if (b !== t.index_b) report($sformatf("index_b %0d, want %0d", b, t.index_b));
         if (c !== t.index_c) report($sformatf("index_c %0d, want %0d", c, t.index_c));
         if (found !== t.found) report($sformatf("found %0d, want %0d", found, t.found));
         if (last !== t.last_result)
            report($sformatf("last_result %0d, want %0d", last, t.last_result));
      endtask
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [bfdt_pkg::COORD_W-1:0]  req_x_coord;
   logic signed [bfdt_pkg::COORD_W-1:0]  req_y_coord;
   logic                                 req_last_point;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [bfdt_pkg::IDX_OUT_W-1:0]       rsp_index_a;
   logic [bfdt_pkg::IDX_OUT_W-1:0]       rsp_index_b;
   logic [bfdt_pkg::IDX_OUT_W-1:0]       rsp_index_c;
   logic                                 rsp_found;
   logic                                 rsp_last_result;
   logic                                 csr_write_enable;
   logic [bfdt_pkg::TOL_W-1:0]           csr_write_data;

   triangle_scoreboard board = new();
   bit  hold_request;       // ask the result side for one long hold-off
   bit  no_gaps;            // run the current set back to back
   int  points_sent;
   int  idle_cycles;

   brute_force_delaunay_triangulation i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_index_a      (rsp_index_a),
      .rsp_index_b      (rsp_index_b),
      .rsp_index_c      (rsp_index_c),
      .rsp_found        (rsp_found),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Mostly short gaps, now and then a long one.
   function int gap_length();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one point item and hold it until the block takes it.
   task send_point(logic signed [bfdt_pkg::COORD_W-1:0] x,
                   logic signed [bfdt_pkg::COORD_W-1:0] y, bit last);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_coord    <= x;
      req_y_coord    <= y;
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      board.note_point(x, y, last);
      points_sent++;
   endtask

   // Drop valid and wait until every predicted result has been taken.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_triangles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tolerance with the block idle; the predictor follows.
   task write_tolerance(bit [bfdt_pkg::TOL_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.tolerance = value;
   endtask

   // Pick a coordinate: full range, a tiny grid (ties, twins, lines) or an extreme.
   function logic signed [bfdt_pkg::COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return bfdt_pkg::COORD_W'($urandom);
      if (r < 8) return bfdt_pkg::COORD_W'($urandom_range(0, 7));
      return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
   endfunction

   task send_random_set(int n);
      for (int p = 0; p < n; p++) send_point(pick_coord(), pick_coord(), p == n - 1);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_index_a, rsp_index_b, rsp_index_c,
                               rsp_found, rsp_last_result);
         if (hold_request) begin
            hold_request = 0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_gaps) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_x_coord      = '0;
      req_y_coord      = '0;
      req_last_point   = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hold_request     = 0;
      no_gaps          = 0;
      points_sent      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets at reset tolerance 0.
      send_point(16'sd5, -16'sd5, 1);                    // too few points: one
      send_point(16'sd1, 16'sd2, 0);                     // too few points: two
      send_point(16'sd3, 16'sd4, 1);
      send_point(16'sd0, 16'sd0, 0);                     // collinear triple
      send_point(16'sd5, 16'sd5, 0);
      send_point(16'sd9, 16'sd9, 1);
      no_gaps = 1;                                       // extreme corners, no idling
      send_point(16'sh8000, 16'sh8000, 0);
      send_point(16'sh7fff, 16'sh8000, 0);
      send_point(16'sd0, 16'sh7fff, 1);
      no_gaps = 0;
      send_point(-16'sd10, -16'sd10, 0);                 // four points on one circle
      send_point(16'sd10, -16'sd10, 0);
      send_point(16'sd10, 16'sd10, 0);
      send_point(-16'sd10, 16'sd10, 1);
      send_point(16'sd0, 16'sd0, 0);                     // duplicate point
      send_point(16'sd0, 16'sd0, 0);
      send_point(16'sd10, 16'sd0, 0);
      send_point(16'sd0, 16'sd10, 1);

      // Full tolerance: small triangles count as collinear; overfill the store
      // and end with a dropped point that still starts the search.
      write_tolerance(16'hffff);
      send_point(16'sd0, 16'sd0, 0);
      send_point(16'sd40, 16'sd0, 0);
      send_point(16'sd0, 16'sd40, 1);
      for (int p = 0; p < bfdt_pkg::MAX_POINTS + 2; p++)
         send_point(bfdt_pkg::COORD_W'($urandom_range(0, 15)),
                    bfdt_pkg::COORD_W'($urandom_range(0, 15)),
                    p == bfdt_pkg::MAX_POINTS + 1);

      write_tolerance(16'd1);
      send_random_set(6);

      // Random phases, each at its own tolerance.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       write_tolerance(16'd0);
            1:       write_tolerance(bfdt_pkg::TOL_W'($urandom_range(1, 255)));
            2:       write_tolerance(bfdt_pkg::TOL_W'($urandom));
            3:       write_tolerance(16'hffff);
            default: write_tolerance(bfdt_pkg::TOL_W'($urandom_range(0, 7)));
         endcase
         if (phase == 1) begin
            // Hold results off while the next set keeps arriving.
            hold_request = 1;
            send_random_set(7);
            send_random_set(5);
         end
         for (int s = 0; s < 1; s++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0:       send_random_set($urandom_range(1, 2));
               1:       send_random_set($urandom_range(9, 10));
               default: send_random_set($urandom_range(3, 8));
            endcase
            no_gaps = 0;
         end
      end

      drain();
      $display("Run covered %0d point items in %0d sets, %0d triangles and %0d empty results.",
               points_sent, board.sets_done, board.triangles_seen, board.empty_seen);
      $display("Tolerances from 0 to 65535, overfilled store, twins, cocircular points.");
      if (board.mismatches == 0 && board.expected_triangles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
